// ----- hw/rtl/tli_pkg.sv -----
`default_nettype none
// ============================================================================
// tli_pkg
// Shared types, constants and saturation helpers for the table interpolator.
// ============================================================================
package tli_pkg;

    localparam int POINTS_DEF = 64;
    localparam int FUNCS_DEF  = 4;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int MAG_W  = DATA_W;
    localparam int QUOT_W = 2 * DATA_W - FRAC_W;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = QUOT_W + 2;

    localparam int REQ_TYPE_W   = 2;
    localparam int POINT_IDX_W  = 6;
    localparam int FUNC_IDX_W   = 2;
    localparam int NUM_POINTS_W = 7;
    localparam int NUM_FUNCS_W  = 3;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic [0:0] REG_NUM_POINTS = 1'b0;
    localparam logic [0:0] REG_NUM_FUNCS  = 1'b1;

    localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RST = 7'd2;
    localparam logic [NUM_FUNCS_W-1:0]  NUM_FUNCS_RST  = 3'd1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_EQUAL_X = 1'b1;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_WRITE_X    = 2'd0,
        REQ_WRITE_Y    = 2'd1,
        REQ_EVAL_VALUE = 2'd2,
        REQ_EVAL_SLOPE = 2'd3
    } tli_req_type_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   req_type;
        logic [POINT_IDX_W-1:0]  point_index;
        logic [FUNC_IDX_W-1:0]   func_index;
        logic signed [DATA_W-1:0] data_value;
    } tli_req_t;

    typedef struct packed {
        logic [FUNC_IDX_W-1:0]    func_index_out;
        logic signed [DATA_W-1:0] result_value;
        logic                     status;
        logic                     last;
    } tli_result_t;

    // magnitude of a sign-extended difference
    function automatic logic [MAG_W-1:0] abs_diff(input logic [MAG_W:0] v);
        logic [MAG_W:0] neg_v;
        neg_v = -v;
        return v[MAG_W] ? neg_v[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // sign and magnitude quotient to saturated data word
    function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                  input logic [QUOT_W-1:0] mag);
        logic [QUOT_W-1:0] lim_pos;
        logic [QUOT_W-1:0] lim_neg;
        logic [DATA_W-1:0] mag_lo;
        lim_pos = {{(QUOT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lim_neg = lim_pos + QUOT_W'(1);
        mag_lo  = mag[DATA_W-1:0];
        if (neg)
        begin
            return (mag > lim_neg) ? {1'b1, {(DATA_W-1){1'b0}}} : -mag_lo;
        end
        return (mag > lim_pos) ? {1'b0, {(DATA_W-1){1'b1}}} : mag_lo;
    endfunction

    function automatic logic [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo_lim = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi_lim)
        begin
            return hi_lim[DATA_W-1:0];
        end
        if (v < lo_lim)
        begin
            return lo_lim[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tli_ram.sv -----
`default_nettype none
// ============================================================================
// tli_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/tli_serdiv.sv -----
`default_nettype none
// ============================================================================
// tli_serdiv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// ============================================================================
module tli_serdiv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tli_pkg::QUOT_W-1:0]  dividend,
    input  wire logic [tli_pkg::MAG_W-1:0]   divisor,
    output logic                             done,
    output logic      [tli_pkg::QUOT_W-1:0]  quotient
);
    import tli_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [QUOT_W-1:0] quo_reg, quo_next;
    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  dvs_reg, dvs_next;
    logic [MAG_W:0]    rem_shift;
    logic [MAG_W+1:0]  trial;
    logic              fits;
    logic              running;

    always_comb
    begin
        running   = (cnt_reg != '0);
        rem_shift = {rem_reg, quo_reg[QUOT_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
        fits      = !trial[MAG_W+1];
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = running && !start && (cnt_reg == CNT_W'(1));
        if (start)
        begin
            cnt_next = CNT_W'(QUOT_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (running)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            rem_next = fits ? trial[MAG_W-1:0] : rem_shift[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/tli_sermul.sv -----
`default_nettype none
// ============================================================================
// tli_sermul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, unsigned.
// ============================================================================
module tli_sermul (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tli_pkg::MAG_W-1:0]  mplier,
    input  wire logic [tli_pkg::MAG_W-1:0]  mcand,
    output logic                            done,
    output logic      [tli_pkg::PROD_W-1:0] product
);
    import tli_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MAG_W-1:0]  mcand_reg, mcand_next;
    logic [MAG_W:0]    part_sum;
    logic              running;

    always_comb
    begin
        running    = (cnt_reg != '0);
        part_sum   = {1'b0, prod_reg[PROD_W-1:MAG_W]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        done_next  = running && !start && (cnt_reg == CNT_W'(1));
        if (start)
        begin
            cnt_next   = CNT_W'(MAG_W);
            prod_next  = {{MAG_W{1'b0}}, mplier};
            mcand_next = mcand;
        end
        else if (running)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            prod_next = {part_sum, prod_reg[MAG_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/table_linear_interpolator.sv -----
`default_nettype none
// ============================================================================
// table_linear_interpolator
// Write beat: taken while idle, no result, busy stays low.
// Evaluate value or slope: busy until the last result beat. The search makes at most
// ceil(log2(n-1)) probes; a value runs the 48-step serial divider once and the 32-step
// serial multiplier per function in use, a slope runs the divider per function in use.
// Each result strobes for one cycle; the receiver cannot stall.
// Reset clears control and config (num_points 2, num_funcs 1); RAMs are not cleared.
// ============================================================================
module table_linear_interpolator #(
    parameter int POINTS = tli_pkg::POINTS_DEF,
    parameter int FUNCS  = tli_pkg::FUNCS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tli_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tli_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tli_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           start,
    input  wire tli_pkg::tli_req_t              req,
    output logic                                busy,
    output logic                                done,
    output tli_pkg::tli_result_t                result
);
    import tli_pkg::*;

    localparam int IW    = $clog2(POINTS);
    localparam int NW    = $clog2(POINTS + 1);
    localparam int CW    = (NW > NUM_POINTS_W) ? NW : NUM_POINTS_W;
    localparam int FCW   = $clog2(FUNCS + 1);
    localparam int FMW   = (FCW > NUM_FUNCS_W) ? FCW : NUM_FUNCS_W;
    localparam int YDEPTH = FUNCS * POINTS;
    localparam int YAW   = $clog2(YDEPTH);

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_RD0  = 15'h0002,
        S_RDN  = 15'h0004,
        S_ASC  = 15'h0008,
        S_PROBE = 15'h0010,
        S_CMP  = 15'h0020,
        S_RDX0 = 15'h0040,
        S_RDX1 = 15'h0080,
        S_CHK  = 15'h0100,
        S_TDIV = 15'h0200,
        S_RDY0 = 15'h0400,
        S_RDY1 = 15'h0800,
        S_YD   = 15'h1000,
        S_MUL  = 15'h2000,
        S_SDIV = 15'h4000
    } tli_state_t;

    // config
    logic [NUM_POINTS_W-1:0] num_points_reg;
    logic [NUM_FUNCS_W-1:0]  num_funcs_reg;
    logic                    cfg_we;
    logic [CW-1:0]           np_raw, n_eff;
    logic [FMW-1:0]          nf_raw, nf_eff;
    logic [IW-1:0]           last_idx;

    // control
    tli_state_t    state_reg, state_next;
    logic          done_reg, done_next;
    logic          slope_reg, slope_next;
    logic          asc_reg, asc_next;
    logic [IW-1:0] lo_reg, lo_next;
    logic [IW-1:0] hi_reg, hi_next;
    logic [IW-1:0] mid_reg, mid_next;
    logic [FCW-1:0] f_reg, f_next;
    logic [YAW-1:0] ybase_reg, ybase_next;

    // datapath
    logic [DATA_W-1:0] xq_reg, xq_next;
    logic [DATA_W-1:0] xfirst_reg, xfirst_next;
    logic [DATA_W-1:0] x0_reg, x0_next;
    logic [DATA_W-1:0] y0_reg, y0_next;
    logic [DATA_W-1:0] t_reg, t_next;
    logic [MAG_W-1:0]  dx_mag_reg, dx_mag_next;
    logic              dx_neg_reg, dx_neg_next;
    logic [MAG_W-1:0]  num_mag_reg, num_mag_next;
    logic              num_neg_reg, num_neg_next;
    logic              neg_reg, neg_next;
    tli_result_t       result_reg, result_next;

    logic              accept;
    logic              x_we, y_we;
    logic [IW-1:0]     x_waddr, x_raddr;
    logic [YAW-1:0]    y_waddr, y_raddr;
    logic [DATA_W-1:0] x_rdata, y_rdata;

    logic [IW:0]       mid_sum;
    logic [IW-1:0]     mid;
    logic [IW-1:0]     span;
    logic [MAG_W:0]    dx_full, num_full, dy_full, t_full;
    logic [MAG_W-1:0]  dy_mag, t_mag;
    logic [FMW-1:0]    f_plus;
    logic              last_func;

    logic                div_start, div_done;
    logic [QUOT_W-1:0]   div_dividend, div_quot;
    logic                mul_start, mul_done;
    logic [PROD_W-1:0]   mul_prod;
    logic signed [SUM_W-1:0] y0_ext, q_ext, val_sum;

    logic              emit;
    logic [DATA_W-1:0] emit_value;

    // ------------------------------------------------------------------ config
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_NUM_POINTS: prdata = APB_DATA_W'(num_points_reg);
            REG_NUM_FUNCS:  prdata = APB_DATA_W'(num_funcs_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        np_raw = CW'(num_points_reg);
        if (np_raw < CW'(2))
        begin
            n_eff = CW'(2);
        end
        else if (np_raw > CW'(POINTS))
        begin
            n_eff = CW'(POINTS);
        end
        else
        begin
            n_eff = np_raw;
        end
        nf_raw = FMW'(num_funcs_reg);
        if (nf_raw < FMW'(1))
        begin
            nf_eff = FMW'(1);
        end
        else if (nf_raw > FMW'(FUNCS))
        begin
            nf_eff = FMW'(FUNCS);
        end
        else
        begin
            nf_eff = nf_raw;
        end
        last_idx = IW'(n_eff - CW'(1));
    end

    // ------------------------------------------------------------------ tables
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign x_we    = accept && (req.req_type == REQ_WRITE_X)
                  && (int'(req.point_index) < POINTS);
    assign y_we    = accept && (req.req_type == REQ_WRITE_Y)
                  && (int'(req.point_index) < POINTS)
                  && (int'(req.func_index) < FUNCS);
    assign x_waddr = IW'(req.point_index);
    assign y_waddr = YAW'(int'(req.func_index) * POINTS + int'(req.point_index));

    tli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (POINTS)
    ) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (req.data_value),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    tli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (YDEPTH)
    ) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (req.data_value),
        .raddr (y_raddr),
        .rdata (y_rdata)
    );

    // ------------------------------------------------------------------ arith
    tli_serdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dx_mag_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    tli_sermul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (t_mag),
        .mcand   (dy_mag),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid      = mid_sum[IW:1];
        span     = hi_reg - lo_reg;
        dx_full  = {x_rdata[DATA_W-1], x_rdata} - {x0_reg[DATA_W-1], x0_reg};
        num_full = {xq_reg[DATA_W-1], xq_reg} - {x0_reg[DATA_W-1], x0_reg};
        dy_full  = {y_rdata[DATA_W-1], y_rdata} - {y0_reg[DATA_W-1], y0_reg};
        t_full   = {t_reg[DATA_W-1], t_reg};
        dy_mag   = abs_diff(dy_full);
        t_mag    = abs_diff(t_full);
        f_plus   = FMW'(f_reg) + FMW'(1);
        last_func = (f_plus == nf_eff);
        y0_ext   = {{(SUM_W-DATA_W){y0_reg[DATA_W-1]}}, y0_reg};
        q_ext    = {{(SUM_W-QUOT_W){1'b0}}, mul_prod[PROD_W-1:FRAC_W]};
        val_sum  = neg_reg ? (y0_ext - q_ext) : (y0_ext + q_ext);
    end

    // ------------------------------------------------------------------ control
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        slope_next   = slope_reg;
        asc_next     = asc_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        f_next       = f_reg;
        ybase_next   = ybase_reg;
        xq_next      = xq_reg;
        xfirst_next  = xfirst_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        t_next       = t_reg;
        dx_mag_next  = dx_mag_reg;
        dx_neg_next  = dx_neg_reg;
        num_mag_next = num_mag_reg;
        num_neg_next = num_neg_reg;
        neg_next     = neg_reg;
        result_next  = result_reg;
        x_raddr      = '0;
        y_raddr      = '0;
        div_start    = 1'b0;
        div_dividend = {num_mag_reg, {FRAC_W{1'b0}}};
        mul_start    = 1'b0;
        emit         = 1'b0;
        emit_value   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.req_type == REQ_EVAL_VALUE
                            || req.req_type == REQ_EVAL_SLOPE))
                begin
                    slope_next = (req.req_type == REQ_EVAL_SLOPE);
                    xq_next    = req.data_value;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                x_raddr    = '0;
                state_next = S_RDN;
            end
            S_RDN:
            begin
                x_raddr     = last_idx;
                xfirst_next = x_rdata;
                state_next  = S_ASC;
            end
            S_ASC:
            begin
                asc_next   = ($signed(x_rdata) >= $signed(xfirst_reg));
                lo_next    = '0;
                hi_next    = last_idx;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                mid_next = mid;
                if (span > IW'(1))
                begin
                    x_raddr    = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    x_raddr    = lo_reg;
                    state_next = S_RDX0;
                end
            end
            S_CMP:
            begin
                if (($signed(xq_reg) >= $signed(x_rdata)) == asc_reg)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_PROBE;
            end
            S_RDX0:
            begin
                x0_next    = x_rdata;
                x_raddr    = lo_reg + IW'(1);
                state_next = S_RDX1;
            end
            S_RDX1:
            begin
                dx_mag_next  = abs_diff(dx_full);
                dx_neg_next  = dx_full[MAG_W];
                num_mag_next = abs_diff(num_full);
                num_neg_next = num_full[MAG_W];
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                f_next     = '0;
                ybase_next = '0;
                if (dx_mag_reg == '0)
                begin
                    result_next.func_index_out = '0;
                    result_next.result_value   = '0;
                    result_next.status         = STATUS_EQUAL_X;
                    result_next.last           = 1'b1;
                    done_next                  = 1'b1;
                    state_next                 = S_IDLE;
                end
                else if (!slope_reg)
                begin
                    div_start  = 1'b1;
                    neg_next   = num_neg_reg ^ dx_neg_reg;
                    state_next = S_TDIV;
                end
                else
                begin
                    state_next = S_RDY0;
                end
            end
            S_TDIV:
            begin
                if (div_done)
                begin
                    t_next     = sat_mag(neg_reg, div_quot);
                    state_next = S_RDY0;
                end
            end
            S_RDY0:
            begin
                y_raddr    = ybase_reg + YAW'(lo_reg);
                state_next = S_RDY1;
            end
            S_RDY1:
            begin
                y0_next    = y_rdata;
                y_raddr    = ybase_reg + YAW'(lo_reg) + YAW'(1);
                state_next = S_YD;
            end
            S_YD:
            begin
                if (slope_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = {dy_mag, {FRAC_W{1'b0}}};
                    neg_next     = dy_full[MAG_W] ^ dx_neg_reg;
                    state_next   = S_SDIV;
                end
                else
                begin
                    mul_start  = 1'b1;
                    neg_next   = t_reg[DATA_W-1] ^ dy_full[MAG_W];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    emit       = 1'b1;
                    emit_value = sat_sum(val_sum);
                end
            end
            S_SDIV:
            begin
                if (div_done)
                begin
                    emit       = 1'b1;
                    emit_value = sat_mag(neg_reg, div_quot);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            result_next.func_index_out = FUNC_IDX_W'(f_reg);
            result_next.result_value   = emit_value;
            result_next.status         = STATUS_OK;
            result_next.last           = last_func;
            done_next                  = 1'b1;
            if (last_func)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                f_next     = f_reg + FCW'(1);
                ybase_next = ybase_reg + YAW'(POINTS);
                state_next = S_RDY0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            slope_reg      <= 1'b0;
            asc_reg        <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
            f_reg          <= '0;
            ybase_reg      <= '0;
            num_points_reg <= NUM_POINTS_RST;
            num_funcs_reg  <= NUM_FUNCS_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            slope_reg <= slope_next;
            asc_reg   <= asc_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            f_reg     <= f_next;
            ybase_reg <= ybase_next;
            if (cfg_we && (paddr[REG_SEL_BIT] == REG_NUM_POINTS))
            begin
                num_points_reg <= pwdata[NUM_POINTS_W-1:0];
            end
            if (cfg_we && (paddr[REG_SEL_BIT] == REG_NUM_FUNCS))
            begin
                num_funcs_reg <= pwdata[NUM_FUNCS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xq_reg      <= xq_next;
        xfirst_reg  <= xfirst_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        t_reg       <= t_next;
        dx_mag_reg  <= dx_mag_next;
        dx_neg_reg  <= dx_neg_next;
        num_mag_reg <= num_mag_next;
        num_neg_reg <= num_neg_next;
        neg_reg     <= neg_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------ checks
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_CHK || state_reg == S_MUL || state_reg == S_SDIV))
        else $error("result beat without a producing step");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |-> !busy)
        else $error("busy after last beat of an evaluation");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_EQUAL_X) |->
            (result.last && result.func_index_out == '0 && result.result_value == '0))
        else $error("malformed equal-breakpoint beat");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == REQ_EVAL_VALUE
                         || req.req_type == REQ_EVAL_SLOPE)) |=> busy)
        else $error("evaluation accepted without going busy");

endmodule
`default_nettype wire

// ----- dv/interp_checker.sv -----
`default_nettype none
// ============================================================================
// interp_checker
// Watches the config port, the request channel and the result strobe of the
// table interpolator. It keeps its own copy of the breakpoint and sample
// tables and of the registers, predicts the results of every accepted
// evaluation and compares each result beat with the oldest prediction.
// ============================================================================
module interp_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [tli_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tli_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire tli_pkg::tli_req_t              req,
    input  wire logic                           done,
    input  wire tli_pkg::tli_result_t           result,
    output int                                  fail_count,
    output int                                  pending
);

    import tli_pkg::*;

    localparam longint Q_ONE = 64'sd65536;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    logic [NUM_POINTS_W-1:0]  points_cfg;
    logic [NUM_FUNCS_W-1:0]   funcs_cfg;
    logic signed [DATA_W-1:0] bkpt_x [POINTS_DEF];
    logic signed [DATA_W-1:0] samp_y [FUNCS_DEF][POINTS_DEF];
    tli_result_t              due_results [$];
    tli_result_t              want;

    function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
        if (v > Q_MAX)
        begin
            return DATA_W'(Q_MAX);
        end
        if (v < Q_MIN)
        begin
            return DATA_W'(Q_MIN);
        end
        return DATA_W'(v);
    endfunction

    function automatic void interpolate(input tli_req_t rq);
        longint      xv;
        longint      x0;
        longint      dx;
        longint      t;
        longint      y0;
        longint      dy;
        longint      r;
        int          n;
        int          nf;
        int          lo;
        int          hi;
        int          mid;
        int          f;
        bit          asc;
        tli_result_t res;
        n  = (points_cfg < 2) ? 2 : (points_cfg > POINTS_DEF) ? POINTS_DEF : int'(points_cfg);
        nf = (funcs_cfg == 0) ? 1 : (funcs_cfg > FUNCS_DEF) ? FUNCS_DEF : int'(funcs_cfg);
        xv = longint'($signed(rq.data_value));
        asc = (longint'(bkpt_x[n-1]) >= longint'(bkpt_x[0]));
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if ((xv >= longint'(bkpt_x[mid])) == asc)
                lo = mid;
            else
                hi = mid;
        end
        x0 = longint'(bkpt_x[lo]);
        dx = longint'(bkpt_x[lo+1]) - x0;
        if (dx == 0)
        begin
            res = '{func_index_out: '0, result_value: '0, status: STATUS_EQUAL_X, last: 1'b1};
            due_results.push_back(res);
            return;
        end
        t = 0;
        if (rq.req_type == REQ_EVAL_VALUE)
            t = clamp_q16((xv - x0) * Q_ONE / dx);
        for (f = 0; f < nf; f++)
        begin
            y0 = longint'(samp_y[f][lo]);
            dy = longint'(samp_y[f][lo+1]) - y0;
            if (rq.req_type == REQ_EVAL_VALUE)
                r = y0 + t * dy / Q_ONE;
            else
                r = dy * Q_ONE / dx;
            res.func_index_out = FUNC_IDX_W'(f);
            res.result_value   = clamp_q16(r);
            res.status         = STATUS_OK;
            res.last           = (f == nf - 1);
            due_results.push_back(res);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_cfg = NUM_POINTS_RST;
            funcs_cfg  = NUM_FUNCS_RST;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            // one result beat per strobe, oldest prediction first
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with no evaluation outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.func_index_out !== want.func_index_out)
                    begin
                        $error("func_index_out: expected %0d, actual %0d",
                               want.func_index_out, result.func_index_out);
                        fail_count++;
                    end
                    if (result.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, actual %0d",
                               $signed(want.result_value), $signed(result.result_value));
                        fail_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        fail_count++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, result.last);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[APB_ADDR_W-1:REG_SEL_BIT] == REG_NUM_POINTS)
                    points_cfg = pwdata[NUM_POINTS_W-1:0];
                else if (paddr[APB_ADDR_W-1:REG_SEL_BIT] == REG_NUM_FUNCS)
                    funcs_cfg = pwdata[NUM_FUNCS_W-1:0];
            end
            if (start && !busy)
            begin
                case (req.req_type)
                    REQ_WRITE_X: bkpt_x[req.point_index] = req.data_value;
                    REQ_WRITE_Y: samp_y[req.func_index][req.point_index] = req.data_value;
                    default:     interpolate(req);
                endcase
            end
            pending <= due_results.size();
        end
    end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
// ============================================================================
// tb
// Drives the table interpolator: a directed opening on a two-point table,
// then phases that set the registers over their whole range, load ascending,
// descending, duplicated or unordered breakpoints and sample tables, and
// issue random value and slope evaluations with random gaps between beats.
// The checker beside the block predicts and compares; this module decides.
// ============================================================================
module tb;

    import tli_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;
    logic                  start;
    tli_req_t              req;
    wire                   busy;
    wire                   done;
    tli_result_t           result;
    int                    fail_count;
    int                    pending;

    longint x_tab [POINTS_DEF];
    bit     y_wr [FUNCS_DEF][POINTS_DEF];
    int     n_eff;
    int     nf_eff;
    int     n_items;
    bit     back_to_back;

    table_linear_interpolator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    interp_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send(input tli_req_type_t ty, input int p, input int f,
                        input logic [DATA_W-1:0] d);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= '{req_type: ty, point_index: POINT_IDX_W'(p), func_index: FUNC_IDX_W'(f),
                   data_value: d};
        do @(posedge clk); while (busy);
        @(negedge clk);
        if (ty == REQ_WRITE_X)
            x_tab[p] = longint'($signed(d));
        else if (ty == REQ_WRITE_Y)
            y_wr[f][p] = 1'b1;
        n_items++;
    endtask

    task automatic reg_write(input logic [0:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle(input int extra);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (extra) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_sample();
        if ($urandom_range(0, 1))
            return $urandom;
        return DATA_W'(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    function automatic logic [DATA_W-1:0] pick_point();
        int     k;
        int     k_end;
        longint a;
        longint b;
        k     = $urandom_range(0, n_eff - 2);
        k_end = $urandom_range(0, 1) ? 0 : n_eff - 1;
        a     = x_tab[k];
        b     = x_tab[k+1];
        case ($urandom_range(0, 7))
            0, 1, 2: return DATA_W'(a + (b - a) * longint'($urandom_range(0, 65535)) / 65536);
            3:       return DATA_W'(a);
            4:       return DATA_W'(b);
            5:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            6:       return DATA_W'(x_tab[k_end] + longint'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return $urandom;
        endcase
    endfunction

    // wide buckets, fine grid, one repeated pair, or no order at all
    task automatic load_breakpoints();
        longint cap;
        longint base;
        longint stepv;
        longint v;
        longint prev;
        int     i;
        int     idx;
        int     style;
        int     dup;
        bit     desc;
        style = $urandom_range(0, 9);
        desc  = $urandom_range(0, 1);
        cap   = 64'sd4294967296 / n_eff;
        base  = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        stepv = longint'($urandom_range(1, 1 << 18));
        dup   = (style == 7) ? $urandom_range(0, n_eff - 2) : -1;
        prev  = 0;
        for (i = 0; i < n_eff; i++)
        begin
            idx = desc ? n_eff - 1 - i : i;
            if (style < 4)
                v = base + idx * stepv;
            else if (style == 8)
                v = longint'($signed($urandom));
            else
                v = -64'sd2147483648 + idx * cap + longint'($urandom_range(0, 32'(cap - 1)));
            if (dup >= 0 && i == dup + 1)
                v = prev;
            prev = v;
            send(REQ_WRITE_X, i, $urandom_range(0, 3), DATA_W'(v));
        end
    endtask

    task automatic fill_samples();
        int f;
        int i;
        for (f = 0; f < nf_eff; f++)
            for (i = 0; i < n_eff; i++)
                if (!y_wr[f][i])
                    send(REQ_WRITE_Y, i, f, rand_sample());
    endtask

    task automatic random_beat();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            send(REQ_WRITE_Y, $urandom_range(0, n_eff - 1), $urandom_range(0, nf_eff - 1),
                 rand_sample());
        else if (r == 1)
            send($urandom_range(0, 1) ? REQ_WRITE_X : REQ_WRITE_Y, $urandom_range(0, 63),
                 $urandom_range(0, 3), $urandom);
        else
            send($urandom_range(0, 1) ? REQ_EVAL_VALUE : REQ_EVAL_SLOPE, $urandom_range(0, 63),
                 $urandom_range(0, 3), pick_point());
    endtask

    initial
    begin
        int ph;
        int np;
        int nfr;
        int new_n;
        int count;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        req     = '0;
        n_eff   = 2;
        nf_eff  = 1;
        n_items = 0;
        back_to_back = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // two-point table under the reset registers
        send(REQ_WRITE_X, 0, 0, 32'hFFFF_0000);
        send(REQ_WRITE_X, 1, 3, 32'h0003_0000);
        send(REQ_WRITE_Y, 0, 0, 32'h8000_0000);
        send(REQ_WRITE_Y, 1, 0, 32'h7FFF_FFFF);
        send(REQ_EVAL_VALUE, 0, 0, 32'h0001_0000);
        send(REQ_EVAL_VALUE, 0, 0, 32'hFFFF_0000);
        send(REQ_EVAL_VALUE, 0, 0, 32'h0003_0000);
        send(REQ_EVAL_VALUE, 0, 0, 32'h8000_0000);
        send(REQ_EVAL_VALUE, 0, 0, 32'h7FFF_FFFF);
        send(REQ_EVAL_SLOPE, 0, 0, 32'h0000_0000);
        // equal breakpoints
        send(REQ_WRITE_X, 1, 0, 32'hFFFF_0000);
        send(REQ_EVAL_VALUE, 0, 0, 32'h0000_0000);
        send(REQ_EVAL_SLOPE, 0, 0, 32'h0000_0000);
        // descending, full span
        send(REQ_WRITE_X, 0, 0, 32'h7FFF_FFFF);
        send(REQ_WRITE_X, 1, 0, 32'h8000_0000);
        send(REQ_EVAL_VALUE, 0, 0, 32'h0000_0000);
        send(REQ_EVAL_SLOPE, 0, 0, 32'h7FFF_FFFF);
        send(REQ_EVAL_VALUE, 0, 0, 32'h8000_0000);
        send(REQ_WRITE_Y, 63, 3, 32'h1234_5678);
        send(REQ_WRITE_X, 63, 3, 32'hFFFF_FFFF);
        settle(8);

        ph = 0;
        while (n_items < 470)
        begin
            case (ph)
                0:       begin np = 64;  nfr = 2; end
                1:       begin np = 127; nfr = 0; end
                2:       begin np = 1;   nfr = 7; end
                3:       begin np = 0;   nfr = 4; end
                4:       begin np = 2;   nfr = 5; end
                default:
                begin
                    np  = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(2, 10);
                    nfr = (np > 16) ? $urandom_range(0, 1) : $urandom_range(0, 7);
                end
            endcase
            reg_write(REG_NUM_POINTS, {25'($urandom), 7'(np)});
            reg_write(REG_NUM_FUNCS, {29'($urandom), 3'(nfr)});
            new_n  = (np < 2) ? 2 : (np > POINTS_DEF) ? POINTS_DEF : np;
            nf_eff = (nfr == 0) ? 1 : (nfr > FUNCS_DEF) ? FUNCS_DEF : nfr;
            back_to_back = ($urandom_range(0, 3) == 0);
            if (new_n != n_eff || $urandom_range(0, 1))
            begin
                n_eff = new_n;
                load_breakpoints();
            end
            fill_samples();
            count = (ph < 2) ? 30 : $urandom_range(6, 18);
            repeat (count) random_beat();
            settle(8);
            ph++;
        end

        settle(300);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/tli_pkg.sv
hw/rtl/tli_ram.sv
hw/rtl/tli_serdiv.sv
hw/rtl/tli_sermul.sv
hw/rtl/table_linear_interpolator.sv
dv/interp_checker.sv
dv/tb.sv
